>>> hdl/signed_64_by_32_divide_unit_core_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef SIGNED_64_BY_32_DIVIDE_UNIT_CORE_MACROS_SVH
`define SIGNED_64_BY_32_DIVIDE_UNIT_CORE_MACROS_SVH

// Same-cycle implication.
`define SD64_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sd64 assertion failed");

// Next-cycle implication.
`define SD64_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sd64 assertion failed");

`endif

>>> hdl/sd64_pkg.sv
`timescale 1ns / 1ps

package sd64_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;

    // Operands handed to the divider at start
    typedef struct packed {
        word_t hi;      // effective high word (already sign-extended if short)
        word_t lo;
        word_t dv;
    } sd64_req_t;

    typedef struct packed {
        word_t res_hi;
        word_t res_lo;
        logic  ovf;
    } sd64_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sd64_status_t;

endpackage

>>> hdl/sd64_channels.sv
`timescale 1ns / 1ps

interface sd64_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sd64_pkg::WORD_W-1:0]  dividend_high;
    logic        [sd64_pkg::WORD_W-1:0]  dividend_low;
    logic signed [sd64_pkg::WORD_W-1:0]  divisor;
    logic                                short_dividend;
    logic                                clear_overflow;

    modport source (output valid, dividend_high, dividend_low, divisor,
                    short_dividend, clear_overflow, input ready);
    modport sink   (input valid, dividend_high, dividend_low, divisor,
                    short_dividend, clear_overflow, output ready);
endinterface

interface sd64_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sd64_pkg::WORD_W-1:0]  result_high;
    logic        [sd64_pkg::WORD_W-1:0]  result_low;
    logic                                overflow;
    logic                                overflow_sticky;

    modport source (output valid, result_high, result_low, overflow,
                    overflow_sticky, input ready);
    modport sink   (input valid, result_high, result_low, overflow,
                    overflow_sticky, output ready);
endinterface

>>> hdl/sd64_divider.sv
`timescale 1ns / 1ps
`include "signed_64_by_32_divide_unit_core_macros.svh"

module sd64_divider
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  sd64_pkg::sd64_req_t     req,
    input  logic                    ack,
    output sd64_pkg::sd64_status_t  status,
    output sd64_pkg::sd64_rsp_t     rsp
);

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_ITER  = 6'b001000,
        ST_FIX   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam int W = sd64_pkg::WORD_W;
    localparam logic [sd64_pkg::CNT_W-1:0] LAST_CNT = sd64_pkg::CNT_W'(W - 1);
    localparam sd64_pkg::word_t MIN_MAG = {1'b1, {(W-1){1'b0}}};

    state_t                      state_reg, state_next;
    logic [sd64_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    sd64_pkg::word_t             hi_reg, lo_reg, dv_reg;
    sd64_pkg::word_t             rem_reg, rem_next;
    sd64_pkg::word_t             quo_reg, quo_next;
    sd64_pkg::word_t             uv_reg;
    logic                        dneg_reg, vneg_reg, ovf_reg;
    sd64_pkg::sd64_rsp_t         rsp_reg, rsp_next;

    logic [2*W-1:0]              dividend;
    logic [2*W-1:0]              ud;
    sd64_pkg::word_t             uv;
    logic [W+1:0]                trial;
    logic                        ge;
    logic                        qneg;
    logic                        range_ovf;

    // Magnitudes of the latched operands
    always_comb
    begin
        dividend = {hi_reg, lo_reg};
        ud       = hi_reg[W-1] ? (~dividend + 1'b1) : dividend;
        uv       = dv_reg[W-1] ? (~dv_reg + 1'b1) : dv_reg;
    end

    // One restoring step: bring down the next dividend bit and try the subtract
    always_comb
    begin
        trial = {1'b0, rem_reg, quo_reg[W-1]} - {2'b00, uv_reg};
        ge    = !trial[W+1];
        if (ge)
        begin
            rem_next = trial[W-1:0];
        end
        else
        begin
            rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
        end
        quo_next = {quo_reg[W-2:0], ge};
    end

    always_comb
    begin
        qneg      = dneg_reg ^ vneg_reg;
        range_ovf = qneg ? (quo_reg > MIN_MAG) : quo_reg[W-1];
        if (ovf_reg || range_ovf)
        begin
            rsp_next.res_hi = hi_reg;
            rsp_next.res_lo = lo_reg;
            rsp_next.ovf    = 1'b1;
        end
        else
        begin
            rsp_next.res_hi = dneg_reg ? (~rem_reg + 1'b1) : rem_reg;
            rsp_next.res_lo = qneg ? (~quo_reg + 1'b1) : quo_reg;
            rsp_next.ovf    = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cnt_next = '0;
                // quotient of 2^32 or more, or divide by zero: no iterations
                if ((uv_reg == '0) || (rem_reg >= uv_reg))
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    hi_reg <= req.hi;
                    lo_reg <= req.lo;
                    dv_reg <= req.dv;
                end
            end
            ST_PREP:
            begin
                rem_reg  <= ud[2*W-1:W];
                quo_reg  <= ud[W-1:0];
                uv_reg   <= uv;
                dneg_reg <= hi_reg[W-1];
                vneg_reg <= dv_reg[W-1];
                ovf_reg  <= 1'b0;
            end
            ST_CHECK:
            begin
                ovf_reg <= (uv_reg == '0) || (rem_reg >= uv_reg);
            end
            ST_ITER:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            ST_FIX:
            begin
                rsp_reg <= rsp_next;
            end
            default:
            begin
            end
        endcase
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign rsp         = rsp_reg;

    `SD64_ASSERT_NOW(a_start_idle, start, state_reg == ST_IDLE)
    `SD64_ASSERT_NOW(a_rem_below_divisor, state_reg == ST_ITER, rem_reg < uv_reg)
    `SD64_ASSERT_NEXT(a_last_step_to_fix, (state_reg == ST_ITER) && (cnt_reg == LAST_CNT),
        state_reg == ST_FIX)
    `SD64_ASSERT_NOW(a_ok_needs_divisor, (state_reg == ST_DONE) && !rsp_reg.ovf,
        uv_reg != '0)

endmodule

>>> hdl/signed_64_by_32_divide_unit_core.sv
`timescale 1ns / 1ps
// Signed 64-by-32 divider with overflow detection.
// request: one transaction per division (dividend_high/low, divisor,
//   short_dividend sign-extends dividend_low into the high word,
//   clear_overflow drops the sticky flag before this division).
// response: one transaction per request; result_high is the remainder and
//   result_low the quotient, or the dividend words with overflow set when
//   the divisor is zero or the quotient does not fit in 32 signed bits.
// Quotient rounds toward zero; the remainder takes the dividend's sign.
// Timing: one bit of quotient per cycle from a 34-bit subtract, 32 steps.
//   An accepted request passes the PREP, CHECK, ITER and FIX states to
//   DONE, where it waits to move into the response register; overflows
//   caught before iterating (divide by zero, quotient of 2^32 or more)
//   skip ITER. One division is in flight at a time; request is ready
//   again the cycle the response goes valid.
// Stall: the response register holds until taken; a finished division waits
//   in the divider meanwhile, and no new request is accepted until it moves
//   into the response register.
// Reset: clears the sticky overflow flag and all handshake state.

module signed_64_by_32_divide_unit_core
(
    input  logic        clk,
    input  logic        rst_n,
    sd64_in_if.sink     request,
    sd64_out_if.source  response
);

    sd64_pkg::sd64_req_t     div_req;
    sd64_pkg::sd64_status_t  div_status;
    sd64_pkg::sd64_rsp_t     div_rsp;
    logic                    start;
    logic                    ack;
    logic                    clr_reg;
    logic                    flag_reg, flag_next;
    logic                    out_valid_reg;
    sd64_pkg::sd64_rsp_t     out_reg;

    assign request.ready = !div_status.busy;
    assign start         = request.valid && request.ready;
    assign ack           = div_status.done && (!out_valid_reg || response.ready);

    always_comb
    begin
        div_req.hi = request.short_dividend ?
                     {sd64_pkg::WORD_W{request.dividend_low[sd64_pkg::WORD_W-1]}} :
                     request.dividend_high;
        div_req.lo = request.dividend_low;
        div_req.dv = request.divisor;
        flag_next  = (flag_reg && !clr_reg) || div_rsp.ovf;
    end

    sd64_divider u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (div_req),
        .ack    (ack),
        .status (div_status),
        .rsp    (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_reg       <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                clr_reg <= request.clear_overflow;
            end
            if (ack)
            begin
                flag_reg      <= flag_next;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            out_reg <= div_rsp;
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.result_high     = out_reg.res_hi;
    assign response.result_low      = out_reg.res_lo;
    assign response.overflow        = out_reg.ovf;
    assign response.overflow_sticky = flag_reg;

endmodule

>>> dv/signed_64_by_32_divide_unit_core_tb.sv
`timescale 1ns / 1ps

module signed_64_by_32_divide_unit_core_tb;

    localparam int RANDOM_DIVISIONS = 450;
    localparam int IDLE_LIMIT       = 2000;
    localparam int LONG_HOLD        = 400;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        sd64_pkg::word_t dividend_high;
        sd64_pkg::word_t dividend_low;
        sd64_pkg::word_t divisor;
        logic            short_dividend;
        logic            clear_overflow;
    } div_request_t;

    typedef struct packed {
        sd64_pkg::word_t result_high;
        sd64_pkg::word_t result_low;
        logic            overflow;
        logic            overflow_sticky;
    } div_result_t;

    logic clk;
    logic rst_n;

    sd64_in_if  req_if ();
    sd64_out_if rsp_if ();

    signed_64_by_32_divide_unit_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    div_request_t pending_divisions[$];
    div_result_t  expected_results[$];
    div_request_t next_division;

    logic sticky_overflow;
    bit   request_taken;
    int   error_count;
    int   results_seen;
    int   idle_cycles;

    // sender burst/gap state
    int burst_left;
    int gap_left;

    // receiver stall state
    int  hold_left;
    int  ready_mode;
    int  mode_left;
    bit  long_hold_done;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic div_result_t predict_quotient(input div_request_t d,
                                                     input logic sticky_in);
        sd64_pkg::word_t hi;
        sd64_pkg::word_t lo;
        sd64_pkg::word_t dv;
        sd64_pkg::word_t mag_v;
        logic [63:0]     dividend;
        logic [63:0]     mag_d;
        logic [63:0]     q;
        logic [63:0]     r;
        logic [63:0]     qs;
        logic [63:0]     rs;
        logic            dneg;
        logic            vneg;
        logic            qneg;
        logic            ovf;
        div_result_t     res;

        lo = d.dividend_low;
        dv = d.divisor;
        hi = d.short_dividend ?
             {sd64_pkg::WORD_W{d.dividend_low[sd64_pkg::WORD_W-1]}} :
             d.dividend_high;
        dividend = {hi, lo};
        dneg = hi[sd64_pkg::WORD_W-1];
        vneg = dv[sd64_pkg::WORD_W-1];
        mag_d = dneg ? -dividend : dividend;
        mag_v = vneg ? -dv : dv;
        ovf = 1'b0;
        res.result_high = hi;
        res.result_low  = lo;
        if (mag_v == '0)
        begin
            ovf = 1'b1;
        end
        else
        begin
            q = mag_d / {32'b0, mag_v};
            r = mag_d % {32'b0, mag_v};
            qneg = dneg ^ vneg;
            // negative quotients may reach -2^31, positive ones stop at 2^31-1
            if (q > (qneg ? 64'h8000_0000 : 64'h7FFF_FFFF))
            begin
                ovf = 1'b1;
            end
            else
            begin
                qs = qneg ? -q : q;
                rs = dneg ? -r : r;
                res.result_low  = qs[sd64_pkg::WORD_W-1:0];
                res.result_high = rs[sd64_pkg::WORD_W-1:0];
            end
        end
        res.overflow        = ovf;
        res.overflow_sticky = (sticky_in & ~d.clear_overflow) | ovf;
        return res;
    endfunction

    task automatic add_division(input sd64_pkg::word_t hi, input sd64_pkg::word_t lo,
                                input sd64_pkg::word_t dv, input logic sh,
                                input logic clr);
        div_request_t d;

        d.dividend_high  = hi;
        d.dividend_low   = lo;
        d.divisor        = dv;
        d.short_dividend = sh;
        d.clear_overflow = clr;
        pending_divisions.push_back(d);
    endtask

    // Prediction on request transactions, checking on response transactions
    always @(posedge clk)
    begin
        div_request_t accepted;
        div_result_t  want;

        if (rst_n)
        begin
            request_taken <= req_if.valid && req_if.ready;

            // pop before push: a request taken now cannot answer this edge
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: hi=%h lo=%h ovf=%b sticky=%b",
                                 rsp_if.result_high, rsp_if.result_low,
                                 rsp_if.overflow, rsp_if.overflow_sticky);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.result_high !== want.result_high ||
                        rsp_if.result_low !== want.result_low ||
                        rsp_if.overflow !== want.overflow ||
                        rsp_if.overflow_sticky !== want.overflow_sticky)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: expected hi=%h lo=%h ovf=%b sticky=%b,",
                                     want.result_high, want.result_low,
                                     want.overflow, want.overflow_sticky,
                                     " got hi=%h lo=%h ovf=%b sticky=%b",
                                     rsp_if.result_high, rsp_if.result_low,
                                     rsp_if.overflow, rsp_if.overflow_sticky);
                    end
                end
            end

            if (req_if.valid && req_if.ready)
            begin
                accepted.dividend_high  = req_if.dividend_high;
                accepted.dividend_low   = req_if.dividend_low;
                accepted.divisor        = req_if.divisor;
                accepted.short_dividend = req_if.short_dividend;
                accepted.clear_overflow = req_if.clear_overflow;
                want = predict_quotient(accepted, sticky_overflow);
                sticky_overflow = want.overflow_sticky;
                expected_results.push_back(want);
            end
        end
    end

    // Request driver: bursts of transactions separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && !request_taken)
            begin
                // hold the offered transaction
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_if.valid <= 1'b0;
            end
            else if (pending_divisions.size() > 0)
            begin
                next_division = pending_divisions.pop_front();
                req_if.valid          <= 1'b1;
                req_if.dividend_high  <= next_division.dividend_high;
                req_if.dividend_low   <= next_division.dividend_low;
                req_if.divisor        <= next_division.divisor;
                req_if.short_dividend <= next_division.short_dividend;
                req_if.clear_overflow <= next_division.clear_overflow;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response receiver: stall pattern with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 150)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 120);
                end
                else
                begin
                    mode_left--;
                end
                case (ready_mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= $urandom_range(0, 1);
                    default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [63:0] wide;
        logic signed [63:0] qv;
        logic signed [63:0] dvv;
        logic signed [31:0] dv32;
        int                 kind;
        int                 off;
        logic               sh;
        logic               clr;

        clk = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.dividend_high = '0;
        req_if.dividend_low = '0;
        req_if.divisor = '0;
        req_if.short_dividend = 1'b0;
        req_if.clear_overflow = 1'b0;
        rsp_if.ready = 1'b0;
        sticky_overflow = 1'b0;
        request_taken = 1'b0;
        error_count = 0;
        results_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        hold_left = 0;
        ready_mode = 0;
        mode_left = 0;
        long_hold_done = 1'b0;

        // remainder sign follows the dividend
        add_division(32'h0000_0000, 32'h0000_0007, 32'h0000_0002, 1'b0, 1'b0);
        add_division(32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'h0000_0002, 1'b0, 1'b0);
        add_division(32'h0000_0000, 32'h0000_0007, 32'hFFFF_FFFE, 1'b0, 1'b0);
        add_division(32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, 1'b0);
        // divide by zero sets the sticky flag, which stays until cleared
        add_division(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 1'b0, 1'b0);
        add_division(32'h0000_0000, 32'h0000_000A, 32'h0000_0003, 1'b0, 1'b0);
        add_division(32'h0000_0000, 32'h0000_000A, 32'h0000_0003, 1'b0, 1'b1);
        // short dividend divided by zero returns the sign-extended high word
        add_division(32'h0000_1234, 32'h8000_0005, 32'h0000_0000, 1'b1, 1'b0);
        // most negative dividend by minus one
        add_division(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // clear and overflow in the same transaction
        add_division(32'h5A5A_5A5A, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_division(32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1);
        // quotient exactly -2^31, then +2^31
        add_division(32'hFFFF_FFFD, 32'h8000_0000, 32'h0000_0005, 1'b0, 1'b0);
        add_division(32'hFFFF_FFFD, 32'h8000_0000, 32'hFFFF_FFFB, 1'b0, 1'b0);
        // largest positive quotient and one past it
        add_division(32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0002, 1'b0, 1'b1);
        add_division(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002, 1'b0, 1'b0);
        add_division(32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0);
        // most negative divisor, and other extreme divisors
        add_division(32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
        add_division(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_division(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
        add_division(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_division(32'hABCD_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        add_division(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        add_division(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
        add_division(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_DIVISIONS; n++)
        begin
            kind = $urandom_range(0, 9);
            wide = {$urandom, $urandom};
            dv32 = $urandom;
            if (kind < 5)
            begin
                // scale both operands so the quotient lands in and out of range
                wide = wide >>> $urandom_range(0, 63);
                dv32 = dv32 >>> $urandom_range(0, 31);
            end
            else if (kind < 8)
            begin
                // aim at the edges of the signed 32-bit quotient range
                case ($urandom_range(0, 3))
                    0: qv = 64'sh7FFF_FFFF;
                    1: qv = -64'sh8000_0000;
                    2: qv = 64'sh8000_0000;
                    default: qv = -64'sh8000_0001;
                endcase
                dv32 = dv32 >>> $urandom_range(0, 31);
                dvv = dv32;
                off = int'($urandom_range(0, 4)) - 2;
                wide = qv * dvv + off;
            end
            if ($urandom_range(0, 15) == 0)
                dv32 = '0;
            sh = ($urandom_range(0, 4) == 0);
            clr = ($urandom_range(0, 6) == 0);
            add_division(sh ? sd64_pkg::word_t'($urandom) : wide[63:32], wide[31:0],
                         dv32, sh, clr);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_divisions.size() > 0 || req_if.valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (60) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
